/* src/rbd_pkg.sv */
`timescale 1ns / 1ps
// rbd_pkg: operation and status codes and the controller command type
// shared by the ring buffer deque controller, datapath and top level
// no dependencies
package rbd_pkg;

  // operation codes carried on the input channel
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  // status codes reported with every result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;  // input transfer: apply the operation
    logic rd;    // read front and back entries of the store
  } rbd_cmd_t;

endpackage

/* src/ring_buffer_deque.sv */
`timescale 1ns / 1ps
// ring_buffer_deque: double-ended queue in a fixed ring store, top level
// depends on rbd_pkg, rbd_ctrl and rbd_datapath
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   input    | in_valid / in_ready   | operation, value
//   output   | out_valid / out_ready | front_value, back_value, count,
//            |                       | is_empty, is_full, status
//
// one item at a time: transfer (pointers, count and store write),
// then a registered two-port read of the ring store, then the result
// is held until its transfer. rst is synchronous and clears pointers,
// count and the sequencer; the store is not cleared. a stalled output
// holds the result and the input.
module ring_buffer_deque #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           operation,
  input  logic [DATA_WIDTH-1:0]                value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [DATA_WIDTH-1:0]                front_value,
  output logic [DATA_WIDTH-1:0]                back_value,
  output logic [$clog2(CAPACITY + 1)-1:0]      count,
  output logic                                 is_empty,
  output logic                                 is_full,
  output logic [1:0]                           status
);
  import rbd_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  rbd_cmd_t cmd;

  // sequencer
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // store and pointers
  rbd_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W),
    .CNT_W      (CNT_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .value       (value),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .status      (status)
  );

endmodule

/* src/rbd_ctrl.sv */
`timescale 1ns / 1ps
// rbd_ctrl: sequencing state machine of the ring buffer deque
// depends on rbd_pkg for the command type
module rbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rbd_pkg::rbd_cmd_t cmd
);
  import rbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshakes and datapath commands
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.exec  = in_ready && in_valid;
  assign cmd.rd    = (state == S_READ);

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at once");
  a_exec_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> cmd.rd)
    else $error("store read did not follow an input transfer");
  a_read_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> out_valid)
    else $error("result not presented after store read");

endmodule

/* src/rbd_datapath.sv */
`timescale 1ns / 1ps
// rbd_datapath: ring store, head/tail pointers, fill count and result registers
// depends on rbd_pkg for operation and status codes and the command type
module rbd_datapath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PTR_W      = $clog2(CAPACITY),
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rbd_pkg::rbd_cmd_t     cmd,
  input  logic [1:0]            operation,
  input  logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] front_value,
  output logic [DATA_WIDTH-1:0] back_value,
  output logic [CNT_W-1:0]      count,
  output logic                  is_empty,
  output logic                  is_full,
  output logic [1:0]            status
);
  import rbd_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      cnt;
  logic [1:0]            status_q;
  logic [DATA_WIDTH-1:0] front_q;
  logic [DATA_WIDTH-1:0] back_q;

  logic [PTR_W-1:0]      head_inc, head_dec, tail_inc, tail_dec;
  logic                  cnt_empty, cnt_full;
  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [PTR_W-1:0]      head_next, tail_next;
  logic [CNT_W-1:0]      cnt_next;
  logic [1:0]            status_next;

  // wrapping pointer neighbors
  assign head_inc  = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign head_dec  = (head == '0) ? PTR_LAST : head - 1'b1;
  assign tail_inc  = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign tail_dec  = (tail == '0) ? PTR_LAST : tail - 1'b1;
  assign cnt_empty = (cnt == '0);
  assign cnt_full  = (cnt == CNT_FULL);

  // operation decode
  always_comb begin
    we          = 1'b0;
    waddr       = tail;
    head_next   = head;
    tail_next   = tail;
    cnt_next    = cnt;
    status_next = ST_OK;
    case (operation)
      OP_PUSH_FRONT: begin
        if (cnt_full) begin
          status_next = ST_OVERFLOW;
        end else begin
          we        = 1'b1;
          waddr     = head_dec;
          head_next = head_dec;
          cnt_next  = cnt + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (cnt_full) begin
          status_next = ST_OVERFLOW;
        end else begin
          we        = 1'b1;
          waddr     = tail;
          tail_next = tail_inc;
          cnt_next  = cnt + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (cnt_empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          head_next = head_inc;
          cnt_next  = cnt - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (cnt_empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          tail_next = tail_dec;
          cnt_next  = cnt - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // pointer, count and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      cnt      <= '0;
      status_q <= ST_OK;
    end else if (cmd.exec) begin
      head     <= head_next;
      tail     <= tail_next;
      cnt      <= cnt_next;
      status_q <= status_next;
    end
  end

  // ring store write port
  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= value;
    end
  end

  // ring store read ports, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      front_q <= mem[head];
      back_q  <= mem[tail_dec];
    end
  end

  // result fields
  assign front_value = cnt_empty ? '0 : front_q;
  assign back_value  = cnt_empty ? '0 : back_q;
  assign count       = cnt;
  assign is_empty    = cnt_empty;
  assign is_full     = cnt_full;
  assign status      = status_q;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("fill count above capacity");
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (status_q == ST_OVERFLOW) |-> cnt_full)
    else $error("overflow reported while not full");
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (status_q == ST_UNDERFLOW) |-> cnt_empty)
    else $error("underflow reported while not empty");
  a_ptr_span: assert property (@(posedge clk) disable iff (rst)
    (cnt_empty || cnt_full) |-> (head == tail))
    else $error("pointers disagree with fill count");

endmodule
